// ----- hw/rtl/furd_pkg.sv -----
// ----------------------------------------------------------------------------
// furd_pkg
// Shared types and constants of the fan unit response deframer.
// ----------------------------------------------------------------------------
package furd_pkg;

	localparam int MAX_UNITS_DEF = 32;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 8;
	localparam int IDX_W   = 5;
	localparam int UCNT_W  = 6;
	localparam int CIDX_W  = 2;
	localparam int TDATA_W = 64;
	localparam int TUSER_W = 3;

	localparam logic [BYTE_W-1:0] MODE_STATE_A = 8'h8A;
	localparam logic [BYTE_W-1:0] MODE_STATE_B = 8'h87;
	localparam logic [BYTE_W-1:0] MODE_SPEED_A = 8'h89;
	localparam logic [BYTE_W-1:0] MODE_SPEED_B = 8'h84;

	localparam logic [POS_W-1:0] LEN_BASE    = 8'd7;
	localparam logic [POS_W-1:0] LEN_SPEED   = 8'd10;
	localparam logic [POS_W-1:0] PAYLOAD_OFS = 8'd5;

	localparam logic [BYTE_W-1:0] RST_START_CODE = 8'd2;
	localparam logic [BYTE_W-1:0] RST_END_CODE   = 8'd3;
	localparam logic [UCNT_W-1:0] RST_UNIT_COUNT = 6'd1;

	typedef enum logic [CIDX_W-1:0] {
		CFG_UNIT_COUNT = 2'd0,
		CFG_START_CODE = 2'd1,
		CFG_END_CODE   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		STAT_UNIT      = 3'd0,
		STAT_SPEED     = 3'd1,
		STAT_BAD_FRAME = 3'd2,
		STAT_BAD_SUM   = 3'd3,
		STAT_BAD_MODE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_HUNT,
		S_COLLECT,
		S_READ,
		S_LOAD
	} fsm_state_t;

	typedef struct packed {
		logic start;
		logic take;
		logic load_single;
		logic rd_en;
		logic load_rec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sc_match;
		logic at_end;
		logic good_state;
		logic out_free;
		logic last_rec;
	} dp_stat_t;

endpackage

// ----- hw/rtl/furd_ram.sv -----
// ----------------------------------------------------------------------------
// furd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module furd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/furd_ctrl.sv -----
// ----------------------------------------------------------------------------
// furd_ctrl
// Frame controller: hunting, collecting and record emission sequencing.
// ----------------------------------------------------------------------------
module furd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  furd_pkg::dp_stat_t   stat,
	output furd_pkg::ctrl_cmd_t  cmd
);

	furd_pkg::fsm_state_t state_q;
	furd_pkg::fsm_state_t state_n;
	logic                 acc;

	assign acc = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= furd_pkg::S_HUNT;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			furd_pkg::S_HUNT: begin
				if (s_tvalid && stat.sc_match) begin
					state_n = furd_pkg::S_COLLECT;
				end
			end
			furd_pkg::S_COLLECT: begin
				if (acc && stat.at_end) begin
					state_n = stat.good_state ? furd_pkg::S_READ : furd_pkg::S_HUNT;
				end
			end
			furd_pkg::S_READ: begin
				state_n = furd_pkg::S_LOAD;
			end
			furd_pkg::S_LOAD: begin
				if (stat.out_free) begin
					state_n = stat.last_rec ? furd_pkg::S_HUNT : furd_pkg::S_READ;
				end
			end
			default: begin
				state_n = furd_pkg::S_HUNT;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			furd_pkg::S_HUNT: begin
				s_tready  = 1'b1;
				cmd.start = s_tvalid & stat.sc_match;
			end
			furd_pkg::S_COLLECT: begin
				// end byte may need the output register
				s_tready        = !stat.at_end || stat.out_free;
				cmd.take        = acc & !stat.at_end;
				cmd.load_single = acc & stat.at_end & !stat.good_state;
			end
			furd_pkg::S_READ: begin
				cmd.rd_en = 1'b1;
			end
			furd_pkg::S_LOAD: begin
				cmd.load_rec = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == furd_pkg::S_READ) |=> (state_q == furd_pkg::S_LOAD))
		else $error("read not followed by load");

	a_load_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == furd_pkg::S_LOAD) && !stat.out_free |=> (state_q == furd_pkg::S_LOAD))
		else $error("record dropped while output busy");

	a_no_input_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == furd_pkg::S_READ) || (state_q == furd_pkg::S_LOAD) |-> !s_tready)
		else $error("input taken during record emission");
`endif

endmodule

// ----- hw/rtl/furd_dp.sv -----
// ----------------------------------------------------------------------------
// furd_dp
// Deframer datapath: config, frame registers, checksum, payload RAM, output.
// ----------------------------------------------------------------------------
module furd_dp #(
	parameter int MAX_UNITS = furd_pkg::MAX_UNITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [furd_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [furd_pkg::BYTE_W-1:0]       cfg_data,
	input  logic [furd_pkg::BYTE_W-1:0]       s_tdata,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [furd_pkg::TDATA_W-1:0]      m_tdata,
	output logic [furd_pkg::TUSER_W-1:0]      m_tuser,
	output logic                              m_tlast,
	input  furd_pkg::ctrl_cmd_t               cmd,
	output furd_pkg::dp_stat_t                stat
);

	localparam int AW   = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
	localparam int UN_W = $clog2(MAX_UNITS + 1);
	localparam int BW   = furd_pkg::BYTE_W;
	localparam int PW   = furd_pkg::POS_W;

	logic [furd_pkg::UCNT_W-1:0] unit_count_q;
	logic [BW-1:0]               start_code_q;
	logic [BW-1:0]               end_code_q;

	logic [PW-1:0]   pos_q;
	logic [PW-1:0]   len_q;
	logic [BW-1:0]   sum_q;
	logic [BW-1:0]   mode1_q;
	logic [BW-1:0]   mode2_q;
	logic [UN_W-1:0] units_q;
	logic [AW-1:0]   rec_q;
	logic [BW-1:0]   asm_q [3];

	logic                        out_valid_q;
	furd_pkg::status_t           out_status_q;
	logic [furd_pkg::IDX_W-1:0]  out_index_q;
	logic [4*BW-1:0]             out_rec_q;
	logic [3*BW-1:0]             out_spd_q;
	logic                        out_last_q;

	logic [PW:0]     pos_p1;
	logic [PW:0]     pos_p2;
	logic [PW-1:0]   pay_idx;
	logic [UN_W-1:0] units_n;
	logic [PW-1:0]   len_n;
	logic            is_state;
	logic            is_speed;
	logic            out_free;
	logic            last_rec;
	logic            ram_we;
	logic [4*BW-1:0] ram_rdata;
	furd_pkg::status_t end_status;

	assign pos_p1  = {1'b0, pos_q} + (PW+1)'(1);
	assign pos_p2  = {1'b0, pos_q} + (PW+1)'(2);
	assign pay_idx = pos_q - furd_pkg::PAYLOAD_OFS;

	assign is_state = (mode1_q == furd_pkg::MODE_STATE_A) && (mode2_q == furd_pkg::MODE_STATE_B);
	assign is_speed = (mode1_q == furd_pkg::MODE_SPEED_A) && (mode2_q == furd_pkg::MODE_SPEED_B);

	// unit count saturated to 1..MAX_UNITS
	always_comb begin
		if (unit_count_q == '0) begin
			units_n = UN_W'(1);
		end else if ({1'b0, unit_count_q} > (furd_pkg::UCNT_W+1)'(MAX_UNITS)) begin
			units_n = UN_W'(MAX_UNITS);
		end else begin
			units_n = UN_W'(unit_count_q);
		end
	end

	always_comb begin
		if ((mode1_q == furd_pkg::MODE_STATE_A) && (s_tdata == furd_pkg::MODE_STATE_B)) begin
			len_n = furd_pkg::LEN_BASE + (PW'(units_n) << 2);
		end else if ((mode1_q == furd_pkg::MODE_SPEED_A) &&
		             (s_tdata == furd_pkg::MODE_SPEED_B)) begin
			len_n = furd_pkg::LEN_SPEED;
		end else begin
			len_n = furd_pkg::LEN_BASE;
		end
	end

	always_comb begin
		if (s_tdata != end_code_q) begin
			end_status = furd_pkg::STAT_BAD_FRAME;
		end else if (sum_q != '0) begin
			end_status = furd_pkg::STAT_BAD_SUM;
		end else if (is_state) begin
			end_status = furd_pkg::STAT_UNIT;
		end else if (is_speed) begin
			end_status = furd_pkg::STAT_SPEED;
		end else begin
			end_status = furd_pkg::STAT_BAD_MODE;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign last_rec = (UN_W'(rec_q) + UN_W'(1)) == units_q;

	assign stat.sc_match   = (s_tdata == start_code_q);
	assign stat.at_end     = pos_p1 >= {1'b0, len_q};
	assign stat.good_state = (end_status == furd_pkg::STAT_UNIT);
	assign stat.out_free   = out_free;
	assign stat.last_rec   = last_rec;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_count_q <= furd_pkg::RST_UNIT_COUNT;
			start_code_q <= furd_pkg::RST_START_CODE;
			end_code_q   <= furd_pkg::RST_END_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				furd_pkg::CFG_UNIT_COUNT: unit_count_q <= cfg_data[furd_pkg::UCNT_W-1:0];
				furd_pkg::CFG_START_CODE: start_code_q <= cfg_data;
				furd_pkg::CFG_END_CODE:   end_code_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= furd_pkg::LEN_BASE;
			sum_q   <= '0;
			mode1_q <= '0;
			mode2_q <= '0;
			units_q <= UN_W'(1);
			rec_q   <= '0;
		end else begin
			if (cmd.start) begin
				pos_q <= PW'(1);
				len_q <= furd_pkg::LEN_BASE;
				sum_q <= '0;
				rec_q <= '0;
			end else if (cmd.take) begin
				if (pos_q == PW'(1)) begin
					mode1_q <= s_tdata;
				end
				if (pos_q == PW'(2)) begin
					mode2_q <= s_tdata;
					len_q   <= len_n;
					units_q <= units_n;
				end
				if (pos_p2 < {1'b0, len_q}) begin
					sum_q <= sum_q + s_tdata;
				end else begin
					sum_q <= sum_q - s_tdata;
				end
				pos_q <= pos_p1[PW-1:0];
			end
			if (cmd.load_rec) begin
				rec_q <= rec_q + AW'(1);
			end
		end
	end

	// payload gathering, four bytes per record word
	assign ram_we = cmd.take && (pos_q >= furd_pkg::PAYLOAD_OFS) &&
	                (pos_p2 < {1'b0, len_q}) && (pay_idx[1:0] == 2'd3);

	always_ff @(posedge clk) begin
		if (cmd.take && (pos_q >= furd_pkg::PAYLOAD_OFS) && (pos_p2 < {1'b0, len_q})) begin
			case (pay_idx[1:0])
				2'd0: asm_q[0] <= s_tdata;
				2'd1: asm_q[1] <= s_tdata;
				2'd2: asm_q[2] <= s_tdata;
				default: begin
				end
			endcase
		end
	end

	furd_ram #(
		.WIDTH (4 * BW),
		.DEPTH (MAX_UNITS),
		.AW    (AW)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pay_idx[AW+1:2]),
		.wdata ({s_tdata, asm_q[2], asm_q[1], asm_q[0]}),
		.re    (cmd.rd_en),
		.raddr (rec_q),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_single || cmd.load_rec) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			out_status_q <= end_status;
			out_index_q  <= '0;
			out_rec_q    <= '0;
			out_spd_q    <= (end_status == furd_pkg::STAT_SPEED) ?
			                {asm_q[2], asm_q[1], asm_q[0]} : '0;
			out_last_q   <= 1'b1;
		end else if (cmd.load_rec) begin
			out_status_q <= furd_pkg::STAT_UNIT;
			out_index_q  <= furd_pkg::IDX_W'(rec_q);
			out_rec_q    <= ram_rdata;
			out_spd_q    <= '0;
			out_last_q   <= last_rec;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_spd_q, out_rec_q, out_index_q};

`ifndef NO_ASSERTIONS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_single || cmd.load_rec) |-> out_free)
		else $error("output register overwritten");

	a_rec_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rec |-> (UN_W'(rec_q) < units_q))
		else $error("record index beyond unit count");

	a_take_before_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (pos_p1 < {1'b0, len_q}))
		else $error("end byte taken as frame data");
`endif

endmodule

// ----- hw/rtl/fan_unit_response_deframer.sv -----
// ----------------------------------------------------------------------------
// fan_unit_response_deframer
// Deframes fan unit controller replies into unit, speed and status results.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while hunting for the start code and while a
// frame is collected. The end byte of a bad, speed or unknown-mode frame gives
// one result at once and is taken only when the output register is free. The
// end byte of a good state frame starts record emission: each of the N unit
// records is a payload RAM read (S_READ), then an output load (S_LOAD) that
// waits for a free output register, and no byte is taken until the last
// record is loaded. The payload RAM needs no clearing pass after reset.
module fan_unit_response_deframer #(
	parameter int MAX_UNITS = furd_pkg::MAX_UNITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [furd_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [furd_pkg::BYTE_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [furd_pkg::BYTE_W-1:0]   s_tdata,  // rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// unit_index, blower_id, present_value, alarm_code, setting_value,
	// range_start, range_end, accept_flag, zero fill
	output logic [furd_pkg::TDATA_W-1:0]  m_tdata,
	output logic [furd_pkg::TUSER_W-1:0]  m_tuser,  // status
	output logic                          m_tlast
);

	furd_pkg::ctrl_cmd_t cmd;
	furd_pkg::dp_stat_t  stat;

	furd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	furd_dp #(
		.MAX_UNITS (MAX_UNITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
